// File: sv/int_to_decimal_ascii_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal ASCII unit
// Shared concurrent assertion forms, clocked on rising edge, reset disabled.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Same-cycle implication
`define ITDA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Widths and character constants for the decimal ASCII unit.
// ----------------------------------------------------------------------------
package itda_pkg;

    // Input integer width
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for any magnitude up to 2^VALUE_BITS - 1
    // (1233/4096 approximates log10(2) from below in this range)
    localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W  = 4 * DIGITS;

    // Counter widths
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_W = $clog2(DIGITS + 1);

    // Characters
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam int         RADIX      = 10;
    localparam logic [7:0] CHAR_NINE  = 8'(48 + RADIX - 1);

    // Converter handshake toward the top level
    typedef struct packed {
        logic done;
        logic busy;
    } t_conv_status;

endpackage

// File: sv/itda_bin2bcd.sv
// ----------------------------------------------------------------------------
// itda_bin2bcd
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module itda_bin2bcd
    import itda_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_bin,
    output t_conv_status          o_status,
    output logic [BCD_W-1:0]      o_bcd
);

    logic [VALUE_BITS-1:0] r_bin;
    logic [VALUE_BITS-1:0] n_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd;
    logic [BCD_W-1:0]      v_adj;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_run;
    logic                  r_done;

    // Add 3 to every digit of 5 or more, then shift in the next binary bit
    always_comb begin
        v_adj = r_bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                v_adj[4*d +: 4] = 4'(r_bcd[4*d +: 4] + 4'd3);
            end
        end
        n_bcd = {v_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
        n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
    end

    // Shift registers, payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_run) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    // Bit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(VALUE_BITS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.busy = r_run;
    assign o_bcd         = r_bcd;

endmodule

// File: sv/int_to_decimal_ascii_unit.sv
// Sequence: accept, the bit-serial shift loop, one handoff, a sign character if negative,
// then each of the DIGITS (10) digit positions in turn, most significant first.
// A new item is accepted only while busy is low, so items never overlap; the pace is
// set by the bit-serial shift-and-add-3 loop and the digit scan.
// Reset (synchronous, active low) returns to idle; no result is in flight.
// The receiver cannot stall: each character is shown for one cycle.
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// Signed integer to decimal ASCII text, most significant character first.
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_unit_macros.svh"

module int_to_decimal_ascii_unit
    import itda_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         busy,
    output logic                         o_valid,
    output logic [7:0]                   o_character,
    output logic                         o_last
);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SIGN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]            r_state;
    logic                  r_neg;
    logic [BCD_W-1:0]      r_digits;
    logic [DIG_W-1:0]      r_left;
    logic                  r_started;
    logic                  r_valid;
    logic [7:0]            r_char;
    logic                  r_last;

    logic                  v_accept;
    logic [VALUE_BITS-1:0] v_raw;
    logic [VALUE_BITS-1:0] v_mag;
    logic [3:0]            v_top;
    logic                  v_final;
    logic                  v_show;
    t_conv_status          conv_status;
    logic [BCD_W-1:0]      conv_bcd;

    // Magnitude of the accepted item
    always_comb begin
        v_accept = start && !busy;
        v_raw    = i_value;
        v_mag    = v_raw[VALUE_BITS-1] ? (~v_raw + 1'b1) : v_raw;
    end

    itda_bin2bcd u_bin2bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (v_accept),
        .i_bin    (v_mag),
        .o_status (conv_status),
        .o_bcd    (conv_bcd)
    );

    // Digit scan: suppress leading zeros, keep the final digit always
    always_comb begin
        v_top   = r_digits[BCD_W-1 -: 4];
        v_final = (r_left == DIG_W'(1));
        v_show  = (v_top != 4'd0) || r_started || v_final;
    end

    // Sequencer and character register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_last    <= 1'b0;
            r_started <= 1'b0;
            r_left    <= '0;
        end else begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (v_accept) begin
                        r_neg   <= v_raw[VALUE_BITS-1];
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (conv_status.done) begin
                        r_digits  <= conv_bcd;
                        r_left    <= DIG_W'(DIGITS);
                        r_started <= 1'b0;
                        r_state   <= r_neg ? S_SIGN : S_EMIT;
                    end
                end
                S_SIGN: begin
                    r_valid <= 1'b1;
                    r_char  <= CHAR_MINUS;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_digits <= {r_digits[BCD_W-5:0], 4'd0};
                    r_left   <= r_left - 1'b1;
                    if (v_show) begin
                        r_started <= 1'b1;
                        r_valid   <= 1'b1;
                        r_char    <= CHAR_ZERO | {4'd0, v_top};
                        r_last    <= v_final;
                    end
                    if (v_final) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // Checks
    `ITDA_ASSERT_SAME(a_last_idle, i_clk, i_rst_n, o_valid && o_last, !busy,
        "final character while still busy")
    `ITDA_ASSERT_SAME(a_char_set, i_clk, i_rst_n, o_valid,
        (o_character == CHAR_MINUS) ||
        ((o_character >= CHAR_ZERO) && (o_character <= CHAR_NINE)),
        "character outside sign and digit set")
    `ITDA_ASSERT_SAME(a_sign_not_last, i_clk, i_rst_n,
        o_valid && (o_character == CHAR_MINUS), !o_last,
        "sign marked as final character")
    `ITDA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy,
        "accepted item did not raise busy")
    `ITDA_ASSERT_SAME(a_conv_in_state, i_clk, i_rst_n, conv_status.busy,
        r_state == S_CONV, "converter running outside conversion state")

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Decimal ASCII unit testbench
// Feeds signed integers through the start/busy handshake and checks every
// emitted character and last flag against a locally computed decimal text.
// ----------------------------------------------------------------------------
module testbench
    import itda_pkg::*;
();

    // One pending input item: the value and the idle cycles that follow it
    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        int unsigned                  gap;
    } t_pending_item;

    // One expected output character
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic signed [VALUE_BITS-1:0] i_value = '0;
    logic                         busy;
    logic                         o_valid;
    logic [7:0]                   o_character;
    logic                         o_last;

    t_pending_item value_queue[$];
    t_text_char    expected_text[$];
    int unsigned   gap_left = 0;
    int unsigned   mismatch_count = 0;

    int_to_decimal_ascii_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_value     (i_value),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR t=%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Expected text of one number: optional '-', then digits, last flag on the final one
    function automatic void spell_decimal(input logic signed [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [7:0]            digits[24];
        int                    nd;
        logic                  negative;
        t_text_char            c;
        negative = v[VALUE_BITS-1];
        mag      = negative ? (~v + 1'b1) : v;
        nd       = 0;
        if (mag == 0) begin
            digits[0] = CHAR_ZERO;
            nd = 1;
        end
        while (mag != 0) begin
            digits[nd] = CHAR_ZERO + 8'(mag % RADIX);
            mag        = mag / RADIX;
            nd++;
        end
        if (negative) begin
            c.ch   = CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c.ch   = digits[i];
            c.last = (i == 0);
            expected_text.push_back(c);
        end
    endfunction

    // Idle length after an item: mostly none or short, now and then long
    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 45)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 120);
    endfunction

    // Random value with a random number of digits and a random sign
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int unsigned nd;
        longint      lo;
        longint      hi;
        longint      mag;
        nd = $urandom_range(1, 10);
        lo = (nd == 1) ? 0 : 64'd10 ** (nd - 1);
        hi = 64'd10 ** nd - 1;
        if (hi > 2147483647)
            hi = 2147483647;
        mag = $urandom_range(int'(hi), int'(lo));
        if ($urandom_range(0, 1))
            mag = -mag;
        return mag[VALUE_BITS-1:0];
    endfunction

    // Driver: present items, predict on acceptance, idle between them
    always @(posedge i_clk) begin : driver
        t_pending_item nxt;
        logic          next_start;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_value  <= '0;
            gap_left <= 0;
        end else begin
            next_start = start;
            if (start && !busy) begin
                spell_decimal(i_value);
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (value_queue.size() != 0) begin
                    nxt        = value_queue.pop_front();
                    next_start = 1'b1;
                    i_value    <= nxt.value;
                    gap_left   <= nxt.gap;
                end
            end
            start <= next_start;
        end
    end

    // Monitor: every strobed character against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_text_char want;
        if (i_rst_n && o_valid) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          o_character, o_last));
            end else begin
                want = expected_text.pop_front();
                if (o_character !== want.ch)
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              o_character, want.ch));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b on 0x%02h",
                                              o_last, want.last, want.ch));
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        logic signed [VALUE_BITS-1:0] directed[$];
        t_pending_item                item;
        bit                           burst;
        burst = 1'b0;
        // extremes, zero, sign, digit-count boundaries
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                     32'sd100, -32'sd100, 32'sd2147483647, 32'h8000_0000,
                     -32'sd2147483647, 32'sd1000000000, 32'sd999999999,
                     -32'sd999999999, -32'sd1000000000, 32'sd123456789,
                     -32'sd5, 32'sd7, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'sd0, -32'sd9};
        foreach (directed[i]) begin
            item.value = directed[i];
            item.gap   = (i < 8) ? 0 : pick_gap(1'b0);
            value_queue.push_back(item);
        end
        for (int n = 0; n < 380; n++) begin
            if ($urandom_range(0, 39) == 0)
                burst = !burst;
            case ($urandom_range(0, 9))
                0, 1, 2: item.value = $urandom;
                9:       item.value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'sd0;
                default: item.value = pick_value();
            endcase
            item.gap = pick_gap(burst);
            value_queue.push_back(item);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (value_queue.size() != 0 || start)
            @(posedge i_clk);
        while (expected_text.size() != 0)
            @(posedge i_clk);
        // drain: catch stray characters after the last expected one
        repeat (60) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
